// ----- hw/rtl/terminal_line_editor_top_assert.svh -----
// assertion macros shared by the line editor modules
`ifndef TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH
`define TERMINAL_LINE_EDITOR_TOP_ASSERT_SVH

// condition implies consequence in the same cycle
`define TLE_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("line editor assertion failed");

// condition implies consequence in the next cycle
`define TLE_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("line editor assertion failed");

`endif

// ----- hw/rtl/tle_pkg.sv -----
`default_nettype none
package tle_pkg;

  // line buffer geometry
  localparam int unsigned LineMax = 64;
  localparam int unsigned AddrW   = $clog2(LineMax);
  localparam int unsigned CntW    = $clog2(LineMax + 1);

  // character codes
  localparam logic [7:0] ChBs    = 8'd8;
  localparam logic [7:0] ChLf    = 8'd10;
  localparam logic [7:0] ChCr    = 8'd13;
  localparam logic [7:0] ChKill  = 8'd21;
  localparam logic [7:0] ChSpace = 8'd32;
  localparam logic [7:0] ChDel   = 8'd127;

  // echo sequences, first byte in the low bits
  localparam logic [23:0] EchoRubout = 24'h082008;
  localparam logic [23:0] EchoCrLf   = 24'h000A0D;

  // configuration register indexes
  localparam logic CfgLineLength = 1'b0;
  localparam logic CfgEchoOn     = 1'b1;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_RUB,
    OP_KILL,
    OP_END
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_KILL,
    ST_LRD,
    ST_LOUT
  } state_e;

  // classified request from front to back
  typedef struct packed {
    op_e        op;
    logic [7:0] ch;
    logic       eoi;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [1:0]      echo_len;
    logic [23:0]     echo_text;
    logic            line_valid;
    logic [7:0]      line_byte;
    logic [CntW-1:0] kept_count;
    logic            end_seen;
    logic            last;
  } res_t;

endpackage
`default_nettype wire

// ----- hw/rtl/terminal_line_editor_top.sv -----
// terminal line editor
// input channel: present a byte on in_byte_i (or end_of_input_i) and raise
// start_i; the request is taken at a clock edge where busy_o is low.
// a front stage classifies each byte and queues up to two requests; a back
// stage applies them to the line buffer and produces the results.
// results: res_valid_o strobes for one cycle per result with the echo and
// line fields; last_o marks the final result of a request. the receiver
// cannot hold results off, so each strobe must be taken when it appears.
// flow: a stored character or rub-out request passes the request queue and
// the back result register before its result appears; ignored bytes give
// no result; ordinary bytes sustain one per cycle while the back stage stays
// idle. kill emits one result per cycle per erased character when echo is on.
// a line end holds the back stage: one step takes the request, then a buffer
// read and an output step per delivered byte alternate in the back state machine.
// configuration: cfg_we_i writes line_length (index 0) or echo_on (index 1);
// write only while the block is idle.
// reset: buffer empty, line_length 64, echo on; buffer contents undefined.
`default_nettype none
module terminal_line_editor_top (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  output logic                           busy_o,
  input  wire logic [7:0]                in_byte_i,
  input  wire logic                      end_of_input_i,
  input  wire logic                      cfg_we_i,
  input  wire logic                      cfg_idx_i,
  input  wire logic [6:0]                cfg_data_i,
  output logic                           res_valid_o,
  output logic [1:0]                     echo_len_o,
  output logic [23:0]                    echo_text_o,
  output logic                           line_valid_o,
  output logic [7:0]                     line_byte_o,
  output logic [tle_pkg::CntW-1:0]       kept_count_o,
  output logic                           end_seen_o,
  output logic                           last_o
);
  import tle_pkg::*;

  logic [6:0]      line_length_q;
  logic            echo_on_q;
  logic [CntW-1:0] len_eff;
  logic            cmd_valid;
  cmd_t            cmd;
  logic            cmd_pop;
  res_t            res;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      line_length_q <= 7'd64;
      echo_on_q     <= 1'b1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CfgLineLength: line_length_q <= cfg_data_i;
        CfgEchoOn:     echo_on_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp line length to 1..LineMax
  always_comb begin
    if (line_length_q == 7'd0) begin
      len_eff = CntW'(1);
    end else if (line_length_q > 7'(LineMax)) begin
      len_eff = CntW'(LineMax);
    end else begin
      len_eff = CntW'(line_length_q);
    end
  end

  tle_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .in_byte_i      (in_byte_i),
    .end_of_input_i (end_of_input_i),
    .busy_o         (busy_o),
    .cmd_valid_o    (cmd_valid),
    .cmd_o          (cmd),
    .cmd_pop_i      (cmd_pop)
  );

  tle_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .len_i       (len_eff),
    .echo_i      (echo_on_q),
    .cmd_valid_i (cmd_valid),
    .cmd_i       (cmd),
    .cmd_pop_o   (cmd_pop),
    .res_valid_o (res_valid_o),
    .res_o       (res)
  );

  // result fields
  assign echo_len_o   = res.echo_len;
  assign echo_text_o  = res.echo_text;
  assign line_valid_o = res.line_valid;
  assign line_byte_o  = res.line_byte;
  assign kept_count_o = res.kept_count;
  assign end_seen_o   = res.end_seen;
  assign last_o       = res.last;

endmodule
`default_nettype wire

// ----- hw/rtl/tle_front.sv -----
`default_nettype none
`include "terminal_line_editor_top_assert.svh"
module tle_front (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [7:0]    in_byte_i,
  input  wire logic          end_of_input_i,
  output logic               busy_o,
  output logic               cmd_valid_o,
  output tle_pkg::cmd_t      cmd_o,
  input  wire logic          cmd_pop_i
);
  import tle_pkg::*;

  cmd_t       fifo_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;
  cmd_t       cls;
  logic       cls_keep;
  logic       accept;
  logic       push;
  logic       pop;

  // classify the incoming byte
  always_comb begin
    cls.ch   = in_byte_i;
    cls.eoi  = end_of_input_i;
    cls.op   = OP_PUT;
    cls_keep = 1'b1;
    if (end_of_input_i) begin
      cls.op = OP_END;
    end else begin
      unique case (in_byte_i) inside
        ChCr, ChLf:   cls.op = OP_END;
        ChBs, ChDel:  cls.op = OP_RUB;
        ChKill:       cls.op = OP_KILL;
        default: begin
          cls.op   = OP_PUT;
          cls_keep = (in_byte_i >= ChSpace);
        end
      endcase
    end
  end

  // two entry request queue
  assign busy_o      = (cnt_q == 2'd2);
  assign accept      = start_i && !busy_o;
  assign push        = accept && cls_keep;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= cls;
    end
  end

  // queue occupancy stays within its depth
  `TLE_ASSERT_IMPL(a_fifo_depth, 1'b1, cnt_q != 2'd3)
  // a pop never happens on an empty queue
  `TLE_ASSERT_IMPL(a_fifo_pop, cmd_pop_i && cnt_q == 2'd0, !pop)

endmodule
`default_nettype wire

// ----- hw/rtl/tle_back.sv -----
`default_nettype none
`include "terminal_line_editor_top_assert.svh"
module tle_back (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic [tle_pkg::CntW-1:0]  len_i,
  input  wire logic                      echo_i,
  input  wire logic                      cmd_valid_i,
  input  wire tle_pkg::cmd_t             cmd_i,
  output logic                           cmd_pop_o,
  output logic                           res_valid_o,
  output tle_pkg::res_t                  res_o
);
  import tle_pkg::*;

  state_e           state_q, state_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [AddrW-1:0] idx_q, idx_d;
  logic [CntW-1:0]  kept_q, kept_d;
  logic             eoi_q, eoi_d;
  logic [7:0]       mem_q [LineMax];
  logic [7:0]       rd_q;
  logic             mem_we;
  res_t             res_d, res_q;
  logic             res_vld_d, res_vld_q;
  logic             line_done;
  logic             take;

  assign take      = (state_q == ST_IDLE) && cmd_valid_i;
  assign cmd_pop_o = take;
  assign line_done = ({1'b0, idx_q} == (len_i - CntW'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (cmd_i.op == OP_END) begin
            state_d = ST_LRD;
          end else if (cmd_i.op == OP_KILL && cnt_q != '0 && echo_i) begin
            state_d = ST_KILL;
          end
        end
      end
      ST_KILL: begin
        if (cnt_q == CntW'(1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_LRD:  state_d = ST_LOUT;
      ST_LOUT: state_d = line_done ? ST_IDLE : ST_LRD;
      default: state_d = ST_IDLE;
    endcase
  end

  // datapath and result outputs
  always_comb begin
    cnt_d     = cnt_q;
    idx_d     = idx_q;
    kept_d    = kept_q;
    eoi_d     = eoi_q;
    mem_we    = 1'b0;
    res_vld_d = 1'b0;
    res_d     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          unique case (cmd_i.op)
            OP_PUT: begin
              if (cnt_q < len_i) begin
                mem_we = 1'b1;
                cnt_d  = cnt_q + CntW'(1);
                if (echo_i) begin
                  res_vld_d       = 1'b1;
                  res_d.echo_len  = 2'd1;
                  res_d.echo_text = {16'h0000, cmd_i.ch};
                  res_d.last      = 1'b1;
                end
              end
            end
            OP_RUB: begin
              if (cnt_q != '0) begin
                cnt_d = cnt_q - CntW'(1);
                if (echo_i) begin
                  res_vld_d       = 1'b1;
                  res_d.echo_len  = 2'd3;
                  res_d.echo_text = EchoRubout;
                  res_d.last      = 1'b1;
                end
              end
            end
            OP_KILL: begin
              if (!echo_i) begin
                cnt_d = '0;
              end
            end
            OP_END: begin
              kept_d = (cnt_q < len_i) ? cnt_q : len_i;
              eoi_d  = cmd_i.eoi;
              idx_d  = '0;
            end
            default: ;
          endcase
        end
      end
      ST_KILL: begin
        cnt_d           = cnt_q - CntW'(1);
        res_vld_d       = 1'b1;
        res_d.echo_len  = 2'd3;
        res_d.echo_text = EchoRubout;
        res_d.last      = (cnt_q == CntW'(1));
      end
      ST_LRD: ;
      ST_LOUT: begin
        res_vld_d        = 1'b1;
        res_d.line_valid = 1'b1;
        res_d.line_byte  = ({1'b0, idx_q} < kept_q) ? rd_q : ChSpace;
        res_d.kept_count = kept_q;
        res_d.end_seen   = eoi_q;
        res_d.last       = line_done;
        if (idx_q == '0 && echo_i) begin
          res_d.echo_len  = 2'd2;
          res_d.echo_text = EchoCrLf;
        end
        if (line_done) begin
          cnt_d = '0;
        end else begin
          idx_d = idx_q + AddrW'(1);
        end
      end
      default: ;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cnt_q     <= '0;
      idx_q     <= '0;
      kept_q    <= '0;
      eoi_q     <= 1'b0;
      res_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      idx_q     <= idx_d;
      kept_q    <= kept_d;
      eoi_q     <= eoi_d;
      res_vld_q <= res_vld_d;
    end
  end

  // result payload register
  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  // line buffer, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[cnt_q[AddrW-1:0]] <= cmd_i.ch;
    end
    rd_q <= mem_q[idx_q];
  end

  assign res_valid_o = res_vld_q;
  assign res_o       = res_q;

  // character count never passes the buffer size
  `TLE_ASSERT_IMPL(a_cnt_max, 1'b1, cnt_q <= CntW'(LineMax))
  // kill echo only runs with characters left
  `TLE_ASSERT_IMPL(a_kill_cnt, state_q == ST_KILL, cnt_q != '0)
  // the last line byte empties the buffer and returns to idle
  `TLE_ASSERT_NEXT(a_line_end, state_q == ST_LOUT && line_done,
                   state_q == ST_IDLE && cnt_q == '0)

endmodule
`default_nettype wire
